### sv/flvtsp_pkg.sv
// Package: shared types, codes and constants of the FLV tag stream parser.
package flvtsp_pkg;

   localparam logic [2:0] PH_FILE    = 3'd0;
   localparam logic [2:0] PH_TAG     = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_TRAILER = 3'd3;

   localparam logic [1:0] KIND_TAG_HEADER = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD    = 2'd1;
   localparam logic [1:0] KIND_ERROR      = 2'd2;

   localparam logic [1:0] ERR_SIGNATURE  = 2'd0;
   localparam logic [1:0] ERR_TYPE_FLAGS = 2'd1;
   localparam logic [1:0] ERR_OFFSET     = 2'd2;
   localparam logic [1:0] ERR_TRAILER    = 2'd3;

   localparam logic [7:0]  FLAG_MASK     = 8'hFA;
   localparam logic [3:0]  FLAG_INDEX    = 4'd4;
   localparam logic [3:0]  HDR_LAST      = 4'd12;
   localparam logic [3:0]  TAG_HDR_LAST  = 4'd10;
   localparam logic [3:0]  TRAILER_LAST  = 4'd3;
   localparam logic [31:0] TAG_HDR_LEN   = 32'd11;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tag_type;
      logic [31:0] timestamp;
      logic [23:0] data_size;
      logic [7:0]  payload_byte;
      logic        last_byte;
      logic [1:0]  error_code;
   } rsp_word_type;

   // expected file header bytes; the flags byte is checked by mask
   function automatic logic [7:0] header_byte(input logic [3:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = 8'h46;
         4'd1:    val = 8'h4C;
         4'd2:    val = 8'h56;
         4'd3:    val = 8'h01;
         4'd8:    val = 8'h09;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

### sv/flvtsp_if.sv
// Interfaces: byte input channel and result word channel.
interface flvtsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface flvtsp_rsp_if;
   logic                      valid;
   logic                      ready;
   flvtsp_pkg::rsp_word_type  word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

### sv/flv_tag_stream_parser_top.sv
// Top level: FLV file header check and tag header / payload / trailer parser.
// One byte word is accepted per clock unless stalled and parsed in the cycle it
// arrives; any result word is registered, or queued if one waits. A two-entry
// output stage (result register plus skid register) lets input continue at one
// byte per clock while a result waits; input stalls only when both are full.
// After any format error one error word is sent and all later bytes are
// accepted and dropped until reset.
module flv_tag_stream_parser_top (
   input  logic                clock,
   input  logic                reset,
   flvtsp_req_if.sink          req_chan,
   flvtsp_rsp_if.source        rsp_chan
);

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [7:0]  tag_kind_ff, tag_kind_in;
   logic [23:0] size_ff, size_in;
   logic [31:0] time_ff, time_in;
   logic [23:0] left_ff, left_in;
   logic [31:0] trailer_ff, trailer_in;
   logic        halted_ff, halted_in;

   logic                     out_valid_ff, skid_valid_ff;
   flvtsp_pkg::rsp_word_type out_ff, skid_ff;

   logic                     accept, take;
   logic                     res_valid;
   flvtsp_pkg::rsp_word_type res;
   logic [7:0]               b;
   logic [3:0]               hdr_i;
   logic                     last;

   assign req_chan.ready = !skid_valid_ff;
   assign accept = req_chan.valid && req_chan.ready;
   assign take = out_valid_ff && rsp_chan.ready;
   assign b = req_chan.data_byte;
   assign hdr_i = (idx_ff > flvtsp_pkg::HDR_LAST) ? flvtsp_pkg::HDR_LAST : idx_ff;
   assign last = (left_ff <= 24'd1);

   always_comb begin
      phase_in = phase_ff;
      idx_in = idx_ff;
      tag_kind_in = tag_kind_ff;
      size_in = size_ff;
      time_in = time_ff;
      left_in = left_ff;
      trailer_in = trailer_ff;
      halted_in = halted_ff;
      res_valid = 1'b0;
      res = '0;
      if (accept && !halted_ff) begin
         unique case (phase_ff)
            flvtsp_pkg::PH_FILE: begin
               if (hdr_i == flvtsp_pkg::FLAG_INDEX &&
                   (b & flvtsp_pkg::FLAG_MASK) != 8'd0) begin
                  res_valid = 1'b1;
                  res.kind = flvtsp_pkg::KIND_ERROR;
                  res.error_code = flvtsp_pkg::ERR_TYPE_FLAGS;
                  halted_in = 1'b1;
               end else if (hdr_i != flvtsp_pkg::FLAG_INDEX &&
                            b != flvtsp_pkg::header_byte(hdr_i)) begin
                  res_valid = 1'b1;
                  res.kind = flvtsp_pkg::KIND_ERROR;
                  res.error_code = (hdr_i < 4'd4) ? flvtsp_pkg::ERR_SIGNATURE
                                                  : flvtsp_pkg::ERR_OFFSET;
                  halted_in = 1'b1;
               end else if (hdr_i == flvtsp_pkg::HDR_LAST) begin
                  phase_in = flvtsp_pkg::PH_TAG;
                  idx_in = 4'd0;
               end else begin
                  idx_in = hdr_i + 4'd1;
               end
            end
            flvtsp_pkg::PH_TAG: begin
               if (idx_ff == 4'd0) begin
                  tag_kind_in = b;
                  size_in = '0;
                  time_in = '0;
               end else if (idx_ff <= 4'd3) begin
                  size_in = {size_ff[15:0], b};
               end else if (idx_ff <= 4'd6) begin
                  time_in = {8'd0, time_ff[15:0], b};
               end else if (idx_ff == 4'd7) begin
                  time_in = {b, time_ff[23:0]};
               end
               if (idx_ff >= flvtsp_pkg::TAG_HDR_LAST) begin
                  idx_in = 4'd0;
                  left_in = size_in;
                  trailer_in = '0;
                  phase_in = (size_in != 24'd0) ? flvtsp_pkg::PH_PAYLOAD
                                                : flvtsp_pkg::PH_TRAILER;
                  res_valid = 1'b1;
                  res.kind = flvtsp_pkg::KIND_TAG_HEADER;
                  res.tag_type = tag_kind_in;
                  res.timestamp = time_in;
                  res.data_size = size_in;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            flvtsp_pkg::PH_PAYLOAD: begin
               res_valid = 1'b1;
               res.kind = flvtsp_pkg::KIND_PAYLOAD;
               res.tag_type = tag_kind_ff;
               res.timestamp = time_ff;
               res.data_size = size_ff;
               res.payload_byte = b;
               res.last_byte = last;
               if (last) begin
                  left_in = '0;
                  phase_in = flvtsp_pkg::PH_TRAILER;
                  idx_in = 4'd0;
                  trailer_in = '0;
               end else begin
                  left_in = left_ff - 24'd1;
               end
            end
            flvtsp_pkg::PH_TRAILER: begin
               trailer_in = {trailer_ff[23:0], b};
               if (idx_ff >= flvtsp_pkg::TRAILER_LAST) begin
                  idx_in = 4'd0;
                  phase_in = flvtsp_pkg::PH_TAG;
                  if (trailer_in != ({8'd0, size_ff} + flvtsp_pkg::TAG_HDR_LEN)) begin
                     res_valid = 1'b1;
                     res.kind = flvtsp_pkg::KIND_ERROR;
                     res.error_code = flvtsp_pkg::ERR_TRAILER;
                     halted_in = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            default: begin
               phase_in = flvtsp_pkg::PH_FILE;
               idx_in = 4'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= flvtsp_pkg::PH_FILE;
         idx_ff <= '0;
         tag_kind_ff <= '0;
         size_ff <= '0;
         time_ff <= '0;
         left_ff <= '0;
         trailer_ff <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff <= idx_in;
         tag_kind_ff <= tag_kind_in;
         size_ff <= size_in;
         time_ff <= time_in;
         left_ff <= left_in;
         trailer_ff <= trailer_in;
         halted_ff <= halted_in;
      end
   end

   // result register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || take) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.word = out_ff;

`ifndef NO_ASSERTIONS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while result register empty");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted cleared without reset");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == flvtsp_pkg::PH_PAYLOAD) |-> (left_ff != 24'd0))
      else $error("payload phase with no bytes left");

   a_halt_no_result: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !res_valid)
      else $error("result produced after error");
`endif

endmodule

### tb/tb_top.sv
// Testbench: FLV tag parser driven byte by byte, results checked against a local predictor.
module tb_top;

   typedef struct packed {
      logic [7:0]               data;
      logic                     typed;
      flvtsp_pkg::rsp_word_type word;
   } flv_row_type;

   localparam int DIR_ROWS = 28;
   localparam logic [7:0] FILE_HDR [13] = '{
      8'h46, 8'h4C, 8'h56, 8'h01, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h09,
      8'h00, 8'h00, 8'h00, 8'h00
   };
   localparam flvtsp_pkg::rsp_word_type EMPTY_TAG_WORD = '{
      kind: flvtsp_pkg::KIND_TAG_HEADER, tag_type: 8'hFF, timestamp: 32'hFFFF_FFFF,
      data_size: 24'd0, payload_byte: 8'd0, last_byte: 1'b0, error_code: 2'd0
   };

   logic clock;
   logic reset;

   flvtsp_req_if req_bus ();
   flvtsp_rsp_if rsp_bus ();

   flv_tag_stream_parser_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // parser shadow state
   logic [2:0]  flv_phase;
   logic [3:0]  flv_index;
   logic [7:0]  flv_type;
   logic [23:0] flv_size;
   logic [31:0] flv_stamp;
   logic [23:0] flv_left;
   logic [31:0] flv_trailer;
   logic        flv_halted;

   flvtsp_pkg::rsp_word_type expected_words [$];
   flvtsp_pkg::rsp_word_type head_word;
   flv_row_type              byte_table [DIR_ROWS];
   int                       fail_count = 0;
   int                       byte_total = 0;
   int                       idle_pct   = 19;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 300000);
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got_v,
                                  input logic [31:0] exp_v);
      $display("mismatch %s: got %0h expected %0h at %0t", field, got_v, exp_v, $realtime);
      fail_count++;
   endtask

   task automatic predict_byte(input logic [7:0] b, output logic got,
                               output flvtsp_pkg::rsp_word_type w);
      logic [3:0] i;
      got = 1'b0;
      w   = '0;
      i   = flv_index;
      if (!flv_halted) begin
         case (flv_phase)
            flvtsp_pkg::PH_FILE: begin
               if (i > flvtsp_pkg::HDR_LAST) i = flvtsp_pkg::HDR_LAST;
               if (i == flvtsp_pkg::FLAG_INDEX && (b & flvtsp_pkg::FLAG_MASK) != 8'd0) begin
                  got = 1'b1;
                  w.kind = flvtsp_pkg::KIND_ERROR;
                  w.error_code = flvtsp_pkg::ERR_TYPE_FLAGS;
               end else if (i != flvtsp_pkg::FLAG_INDEX && b != FILE_HDR[i]) begin
                  got = 1'b1;
                  w.kind = flvtsp_pkg::KIND_ERROR;
                  w.error_code = (i < flvtsp_pkg::FLAG_INDEX) ? flvtsp_pkg::ERR_SIGNATURE
                                                              : flvtsp_pkg::ERR_OFFSET;
               end else if (i == flvtsp_pkg::HDR_LAST) begin
                  flv_phase = flvtsp_pkg::PH_TAG;
                  flv_index = 4'd0;
               end else begin
                  flv_index = i + 4'd1;
               end
            end
            flvtsp_pkg::PH_TAG: begin
               if (i == 4'd0) begin
                  flv_type  = b;
                  flv_size  = 24'd0;
                  flv_stamp = 32'd0;
               end else if (i <= 4'd3) begin
                  flv_size = {flv_size[15:0], b};
               end else if (i <= 4'd6) begin
                  flv_stamp = {8'd0, flv_stamp[15:0], b};
               end else if (i == 4'd7) begin
                  flv_stamp = {b, flv_stamp[23:0]};
               end
               if (i == flvtsp_pkg::TAG_HDR_LAST) begin
                  flv_index   = 4'd0;
                  flv_left    = flv_size;
                  flv_trailer = 32'd0;
                  flv_phase   = (flv_size != 24'd0) ? flvtsp_pkg::PH_PAYLOAD
                                                    : flvtsp_pkg::PH_TRAILER;
                  got = 1'b1;
                  w.kind = flvtsp_pkg::KIND_TAG_HEADER;
                  w.tag_type = flv_type;
                  w.timestamp = flv_stamp;
                  w.data_size = flv_size;
               end else begin
                  flv_index = i + 4'd1;
               end
            end
            flvtsp_pkg::PH_PAYLOAD: begin
               got = 1'b1;
               w.kind = flvtsp_pkg::KIND_PAYLOAD;
               w.tag_type = flv_type;
               w.timestamp = flv_stamp;
               w.data_size = flv_size;
               w.payload_byte = b;
               w.last_byte = (flv_left <= 24'd1);
               if (flv_left <= 24'd1) begin
                  flv_left    = 24'd0;
                  flv_phase   = flvtsp_pkg::PH_TRAILER;
                  flv_index   = 4'd0;
                  flv_trailer = 32'd0;
               end else begin
                  flv_left = flv_left - 24'd1;
               end
            end
            flvtsp_pkg::PH_TRAILER: begin
               flv_trailer = {flv_trailer[23:0], b};
               if (i >= flvtsp_pkg::TRAILER_LAST) begin
                  flv_index = 4'd0;
                  flv_phase = flvtsp_pkg::PH_TAG;
                  if (flv_trailer != {8'd0, flv_size} + flvtsp_pkg::TAG_HDR_LEN) begin
                     got = 1'b1;
                     w.kind = flvtsp_pkg::KIND_ERROR;
                     w.error_code = flvtsp_pkg::ERR_TRAILER;
                  end
               end else begin
                  flv_index = i + 4'd1;
               end
            end
            default: begin
               flv_phase = flvtsp_pkg::PH_FILE;
               flv_index = 4'd0;
            end
         endcase
         if (got && w.kind == flvtsp_pkg::KIND_ERROR) flv_halted = 1'b1;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input flvtsp_pkg::rsp_word_type tw);
      logic                     got;
      flvtsp_pkg::rsp_word_type w;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      byte_total++;
      predict_byte(b, got, w);
      if (typed) expected_words.push_back(tw);
      else if (got) expected_words.push_back(w);
   endtask

   task automatic send_tag(input logic [7:0] kind_b, input logic [23:0] size,
                           input logic [31:0] stamp, input logic bad_trailer);
      logic [31:0] trailer;
      send_byte(kind_b, 1'b0, '0);
      send_byte(size[23:16], 1'b0, '0);
      send_byte(size[15:8], 1'b0, '0);
      send_byte(size[7:0], 1'b0, '0);
      send_byte(stamp[23:16], 1'b0, '0);
      send_byte(stamp[15:8], 1'b0, '0);
      send_byte(stamp[7:0], 1'b0, '0);
      send_byte(stamp[31:24], 1'b0, '0);
      repeat (3) send_byte(8'($urandom_range(255)), 1'b0, '0);
      for (int k = 0; k < int'(size); k++) send_byte(8'($urandom_range(255)), 1'b0, '0);
      trailer = {8'd0, size} + flvtsp_pkg::TAG_HDR_LEN;
      if (bad_trailer)
         trailer = trailer ^ (32'($urandom_range(254) + 1) << (8 * $urandom_range(3)));
      send_byte(trailer[31:24], 1'b0, '0);
      send_byte(trailer[23:16], 1'b0, '0);
      send_byte(trailer[15:8], 1'b0, '0);
      send_byte(trailer[7:0], 1'b0, '0);
   endtask

   // result side: check, then stall at random
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, kind", 32'(rsp_bus.word.kind), 32'd0);
         end else begin
            head_word = expected_words.pop_front();
            if (rsp_bus.word.kind !== head_word.kind)
               report_mismatch("kind", 32'(rsp_bus.word.kind), 32'(head_word.kind));
            if (rsp_bus.word.tag_type !== head_word.tag_type)
               report_mismatch("tag_type", 32'(rsp_bus.word.tag_type),
                               32'(head_word.tag_type));
            if (rsp_bus.word.timestamp !== head_word.timestamp)
               report_mismatch("timestamp", rsp_bus.word.timestamp, head_word.timestamp);
            if (rsp_bus.word.data_size !== head_word.data_size)
               report_mismatch("data_size", 32'(rsp_bus.word.data_size),
                               32'(head_word.data_size));
            if (rsp_bus.word.payload_byte !== head_word.payload_byte)
               report_mismatch("payload_byte", 32'(rsp_bus.word.payload_byte),
                               32'(head_word.payload_byte));
            if (rsp_bus.word.last_byte !== head_word.last_byte)
               report_mismatch("last_byte", 32'(rsp_bus.word.last_byte),
                               32'(head_word.last_byte));
            if (rsp_bus.word.error_code !== head_word.error_code)
               report_mismatch("error_code", 32'(rsp_bus.word.error_code),
                               32'(head_word.error_code));
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
   end

   initial begin
      logic [23:0] size;
      int          pick;
      int          wait_cycles;
      byte_table = '{
         '{8'h46, 1'b0, '0}, '{8'h4C, 1'b0, '0}, '{8'h56, 1'b0, '0}, '{8'h01, 1'b0, '0},
         '{8'h05, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
         '{8'h09, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         // empty tag, all-ones type and timestamp
         '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
         '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
         '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b1, EMPTY_TAG_WORD},
         '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h0B, 1'b0, '0}
      };
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'd0;
      rsp_bus.ready     = 1'b0;
      flv_phase   = flvtsp_pkg::PH_FILE;
      flv_index   = 4'd0;
      flv_type    = 8'd0;
      flv_size    = 24'd0;
      flv_stamp   = 32'd0;
      flv_left    = 24'd0;
      flv_trailer = 32'd0;
      flv_halted  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++)
         send_byte(byte_table[r].data, byte_table[r].typed, byte_table[r].word);

      while (byte_total < 1200) begin
         idle_pct = (byte_total >= 450 && byte_total < 750) ? 0 : 19;
         pick = $urandom_range(99);
         if (pick < 10)      size = 24'd0;
         else if (pick < 85) size = 24'($urandom_range(16, 1));
         else if (pick < 97) size = 24'($urandom_range(64, 17));
         else                size = 24'($urandom_range(400, 100));
         send_tag(8'($urandom_range(255)), size, $urandom(), 1'b0);
      end
      idle_pct = 19;

      // bad trailer halts the parser; later bytes are dropped
      send_tag(8'($urandom_range(255)), 24'($urandom_range(8)), $urandom(), 1'b1);
      repeat (40) send_byte(8'($urandom_range(255)), 1'b0, '0);
      req_bus.valid <= 1'b0;

      wait_cycles = 0;
      while (expected_words.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch("words never arrived", 32'(expected_words.size()), 32'd0);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
sv/flvtsp_pkg.sv
sv/flvtsp_if.sv
sv/flv_tag_stream_parser_top.sv
tb/tb_top.sv
